FILE: rtl/core/itf_pkg.sv
package itf_pkg;

   // Size limits
   localparam int MAX_WIDTH  = 64;
   localparam int VALUE_BITS = 64;
   localparam int PREC_LIMIT = 62;

   // Digit slots: octal needs the most of them
   localparam int NUM_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int LEN_MAX    = (MAX_WIDTH > PREC_LIMIT + 2) ? MAX_WIDTH : PREC_LIMIT + 2;
   localparam int LEN_W      = $clog2(LEN_MAX + 1);
   localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
   localparam int CONV_W     = $clog2(VALUE_BITS + 1);

   // Conversion kinds
   localparam logic [2:0] FUNC_SDEC = 3'd0;
   localparam logic [2:0] FUNC_UDEC = 3'd1;
   localparam logic [2:0] FUNC_OCT  = 3'd2;
   localparam logic [2:0] FUNC_HEXL = 3'd3;
   localparam logic [2:0] FUNC_HEXU = 3'd4;
   localparam logic [2:0] FUNC_PTR  = 3'd5;

   // Flag bit positions
   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_ZERO  = 1;
   localparam int FLAG_PLUS  = 2;
   localparam int FLAG_SPACE = 3;
   localparam int FLAG_ALT   = 4;

   // Digit slot behavior while bits shift in
   typedef logic [1:0] base_type;
   localparam base_type BASE_DEC = 2'd0;
   localparam base_type BASE_OCT = 2'd1;
   localparam base_type BASE_HEX = 2'd2;

   // ASCII characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   // Map one digit value to its character
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] d8;
      d8 = {4'b0000, d};
      if (d < 4'd10) begin
         return CH_ZERO + d8;
      end else if (upper) begin
         return CH_UA + d8 - 8'd10;
      end else begin
         return CH_LA + d8 - 8'd10;
      end
   endfunction

endpackage

FILE: rtl/core/integer_to_text_formatter_top.sv
// Integer to text formatter, printf-style integer conversions.
// Request channel (req_*): one value with its conversion kind, flags, field
// width and precision, taken at a clock edge with req_valid high and
// req_stall low. req_stall stays high from the transfer until the last
// character of that value has been handed to the output register.
// Response channel (rsp_*): one ASCII character per transfer, rsp_last set on
// the final character of each value's text.
// Sequence: the value shifts one bit per cycle into a row of digit slots,
// a leading-zero scan drops zero slots, keeping at least one, the setup
// states ST_SETUP_A and ST_SETUP_B follow, then one character is loaded
// per cycle while the receiver takes them. Leading-zero slots plus digits
// always number 22. A new request is not taken until the last character
// of the value has been loaded; the serial bit shift and the one-character
// output port limit the request rate. The next request is taken while the
// final character still waits in the output register.
// A stalled receiver holds the output register and the character sequence
// simply pauses. Synchronous reset returns to idle and drops any pending
// character.
module integer_to_text_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_value_bits,
   input  logic [4:0]  req_flag_set,
   input  logic [6:0]  req_field_width,
   input  logic [5:0]  req_min_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   localparam int VB = itf_pkg::VALUE_BITS;
   localparam int ND = itf_pkg::NUM_DIGITS;
   localparam int LW = itf_pkg::LEN_W;
   localparam int DW = itf_pkg::DIG_W;
   localparam int CW = itf_pkg::CONV_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CONVERT = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_SETUP_A = 3'd3;
   localparam logic [2:0] ST_SETUP_B = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           conv_cnt_ff, conv_cnt_in;
   logic [VB-1:0]           mag_ff, mag_in;
   logic [4*ND-1:0]         digit_ff, digit_in;
   logic [2:0]              func_ff, func_in;
   itf_pkg::base_type       mode_ff, mode_in;
   logic [4:0]              flags_ff, flags_in;
   logic [LW-1:0]           width_ff, width_in;
   logic [LW-1:0]           prec_ff, prec_in;
   logic                    neg_ff, neg_in;
   logic                    nonzero_ff, nonzero_in;
   logic [DW-1:0]           ndig_ff, ndig_in;
   logic [1:0]              npre_ff, npre_in;
   logic [7:0]              pre0_ff, pre0_in;
   logic [7:0]              pre1_ff, pre1_in;
   logic [LW-1:0]           pzero_ff, pzero_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [LW-1:0]           b1_ff, b1_in;
   logic [LW-1:0]           b2_ff, b2_in;
   logic [LW-1:0]           b3_ff, b3_in;
   logic [LW-1:0]           b4_ff, b4_in;
   logic [LW-1:0]           total_ff, total_in;
   logic [LW-1:0]           pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_take;
   logic                    emit_go;
   logic [4*ND-1:0]         shifted;
   logic [ND:0]             carry;
   logic [3:0]              top_digit;

   assign req_stall    = reset || (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign emit_go      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign top_digit    = digit_ff[4*ND-1 -: 4];
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // Shift one value bit into the digit slots, with decimal add-3 correction
   always_comb begin
      logic [3:0] d_cur;
      logic [3:0] d_adj;
      carry[0] = mag_ff[VB-1];
      shifted  = '0;
      for (int i = 0; i < ND; i++) begin
         d_cur = digit_ff[4*i +: 4];
         d_adj = (d_cur >= 4'd5) ? d_cur + 4'd3 : d_cur;
         unique case (mode_ff)
            itf_pkg::BASE_DEC: begin
               carry[i+1]        = d_adj[3];
               shifted[4*i +: 4] = {d_adj[2:0], carry[i]};
            end
            itf_pkg::BASE_OCT: begin
               carry[i+1]        = d_cur[2];
               shifted[4*i +: 4] = {1'b0, d_cur[1:0], carry[i]};
            end
            default: begin
               carry[i+1]        = d_cur[3];
               shifted[4*i +: 4] = {d_cur[2:0], carry[i]};
            end
         endcase
      end
   end

   // Sequencer and per-item datapath
   always_comb begin
      logic [VB-1:0] v;
      logic          vneg;
      logic [LW-1:0] w_ext;
      logic [LW-1:0] ndig_ext;
      logic [LW-1:0] nd;
      logic [LW-1:0] pad;
      logic [LW-1:0] lead;
      logic [LW-1:0] zpad;
      logic [LW-1:0] trail;
      logic          zfill;

      state_in    = state_ff;
      conv_cnt_in = conv_cnt_ff;
      mag_in      = mag_ff;
      digit_in    = digit_ff;
      func_in     = func_ff;
      mode_in     = mode_ff;
      flags_in    = flags_ff;
      width_in    = width_ff;
      prec_in     = prec_ff;
      neg_in      = neg_ff;
      nonzero_in  = nonzero_ff;
      ndig_in     = ndig_ff;
      npre_in     = npre_ff;
      pre0_in     = pre0_ff;
      pre1_in     = pre1_ff;
      pzero_in    = pzero_ff;
      len_in      = len_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      b3_in       = b3_ff;
      b4_in       = b4_ff;
      total_in    = total_ff;
      pos_in      = pos_ff;

      v        = req_value_bits[VB-1:0];
      vneg     = (req_func == itf_pkg::FUNC_SDEC) && v[VB-1];
      w_ext    = LW'(req_field_width);
      ndig_ext = LW'(ndig_ff);
      nd       = (ndig_ext > prec_ff) ? ndig_ext : prec_ff;
      zfill    = flags_ff[itf_pkg::FLAG_ZERO] && !flags_ff[itf_pkg::FLAG_LEFT];
      pad      = (width_ff > len_ff) ? width_ff - len_ff : '0;
      lead     = (!flags_ff[itf_pkg::FLAG_LEFT] && !zfill) ? pad : '0;
      zpad     = zfill ? pad : '0;
      trail    = flags_ff[itf_pkg::FLAG_LEFT] ? pad : '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Capture the request, take the magnitude
            if (req_take) begin
               func_in     = req_func;
               flags_in    = req_flag_set;
               neg_in      = vneg;
               nonzero_in  = (v != '0);
               mag_in      = vneg ? (~v) + VB'(1) : v;
               digit_in    = '0;
               conv_cnt_in = CW'(VB);
               width_in    = (w_ext > LW'(itf_pkg::MAX_WIDTH)) ?
                             LW'(itf_pkg::MAX_WIDTH) : w_ext;
               if (req_func == itf_pkg::FUNC_PTR) begin
                  prec_in = '0;
               end else if (req_min_digit_count > 6'(itf_pkg::PREC_LIMIT)) begin
                  prec_in = LW'(itf_pkg::PREC_LIMIT);
               end else begin
                  prec_in = LW'(req_min_digit_count);
               end
               unique case (req_func)
                  itf_pkg::FUNC_OCT:  mode_in = itf_pkg::BASE_OCT;
                  itf_pkg::FUNC_HEXL,
                  itf_pkg::FUNC_HEXU,
                  itf_pkg::FUNC_PTR:  mode_in = itf_pkg::BASE_HEX;
                  default:            mode_in = itf_pkg::BASE_DEC;
               endcase
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Advance one bit per cycle
            digit_in    = shifted;
            mag_in      = mag_ff << 1;
            conv_cnt_in = conv_cnt_ff - CW'(1);
            if (conv_cnt_ff == CW'(1)) begin
               ndig_in  = DW'(ND);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Drop leading zero digits, keep at least one
            if (top_digit == 4'd0 && ndig_ff > DW'(1)) begin
               digit_in = digit_ff << 4;
               ndig_in  = ndig_ff - DW'(1);
            end else begin
               state_in = ST_SETUP_A;
            end
         end
         ST_SETUP_A: begin
            // Pick the sign or prefix and the digit count
            npre_in = 2'd0;
            pre0_in = itf_pkg::CH_ZERO;
            pre1_in = itf_pkg::CH_LX;
            if (func_ff == itf_pkg::FUNC_SDEC) begin
               if (neg_ff) begin
                  npre_in = 2'd1;
                  pre0_in = itf_pkg::CH_MINUS;
               end else if (flags_ff[itf_pkg::FLAG_PLUS]) begin
                  npre_in = 2'd1;
                  pre0_in = itf_pkg::CH_PLUS;
               end else if (flags_ff[itf_pkg::FLAG_SPACE]) begin
                  npre_in = 2'd1;
                  pre0_in = itf_pkg::CH_SPACE;
               end
            end else if (func_ff == itf_pkg::FUNC_PTR) begin
               npre_in = 2'd2;
            end else if (flags_ff[itf_pkg::FLAG_ALT] && nonzero_ff) begin
               if (func_ff == itf_pkg::FUNC_OCT) begin
                  // a precision zero already leads the digits
                  if (prec_ff <= ndig_ext) begin
                     npre_in = 2'd1;
                  end
               end else if (func_ff == itf_pkg::FUNC_HEXL ||
                            func_ff == itf_pkg::FUNC_HEXU) begin
                  npre_in = 2'd2;
                  if (func_ff == itf_pkg::FUNC_HEXU) begin
                     pre1_in = itf_pkg::CH_UX;
                  end
               end
            end
            pzero_in = nd - ndig_ext;
            len_in   = LW'(npre_in) + nd;
            state_in = ST_SETUP_B;
         end
         ST_SETUP_B: begin
            // Segment boundaries of the text
            b1_in    = lead;
            b2_in    = lead + LW'(npre_ff);
            b3_in    = lead + LW'(npre_ff) + zpad + pzero_ff;
            b4_in    = lead + LW'(npre_ff) + zpad + pzero_ff + ndig_ext;
            total_in = lead + len_ff + zpad + trail;
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Advance one character per output transfer
            if (emit_go) begin
               pos_in = pos_ff + LW'(1);
               if (pos_ff >= b3_ff && pos_ff < b4_ff) begin
                  digit_in = digit_ff << 4;
               end
               if (pos_ff + LW'(1) == total_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (pos_ff + LW'(1) == total_ff);
         priority if (pos_ff < b1_ff) begin
            rsp_char_in = itf_pkg::CH_SPACE;
         end else if (pos_ff < b2_ff) begin
            rsp_char_in = (pos_ff == b1_ff) ? pre0_ff : pre1_ff;
         end else if (pos_ff < b3_ff) begin
            rsp_char_in = itf_pkg::CH_ZERO;
         end else if (pos_ff < b4_ff) begin
            rsp_char_in = itf_pkg::digit_char(top_digit, func_ff == itf_pkg::FUNC_HEXU);
         end else begin
            rsp_char_in = itf_pkg::CH_SPACE;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      conv_cnt_ff <= conv_cnt_in;
      mag_ff      <= mag_in;
      digit_ff    <= digit_in;
      func_ff     <= func_in;
      mode_ff     <= mode_in;
      flags_ff    <= flags_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      neg_ff      <= neg_in;
      nonzero_ff  <= nonzero_in;
      ndig_ff     <= ndig_in;
      npre_ff     <= npre_in;
      pre0_ff     <= pre0_in;
      pre1_ff     <= pre1_in;
      pzero_ff    <= pzero_in;
      len_ff      <= len_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      total_ff    <= total_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
